// ===== hw/rtl/spirv_module_envelope_checker_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the SPIR-V module envelope checker
// Clocked, reset-qualified wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SPIRV_MODULE_ENVELOPE_CHECKER_ASSERT_SVH
`define SPIRV_MODULE_ENVELOPE_CHECKER_ASSERT_SVH

// A property that must hold in every cycle out of reset.
`define SMEC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define SMEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/smec_pkg.sv =====
// ----------------------------------------------------------------------------
// smec_pkg
// Types, constants and the opcode minimum table of the envelope checker.
// ----------------------------------------------------------------------------
package smec_pkg;

    localparam int unsigned IDX_W = 21;
    localparam int unsigned LEN_W = 16;
    localparam int unsigned MIN_W = 3;

    localparam logic [IDX_W-1:0] MAX_WORDS_LIMIT = 21'd1048576;
    localparam logic [IDX_W-1:0] SIZE_LIMIT_RESET = 21'd262144;
    localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};
    localparam logic [IDX_W-1:0] HEADER_WORDS = 21'd5;

    localparam logic [IDX_W-1:0] HDR_MAGIC_IDX = 21'd0;
    localparam logic [IDX_W-1:0] HDR_VERSION_IDX = 21'd1;
    localparam logic [IDX_W-1:0] HDR_BOUND_IDX = 21'd3;
    localparam logic [IDX_W-1:0] HDR_SCHEMA_IDX = 21'd4;

    localparam logic [31:0] MAGIC_WORD = 32'h0723_0203;
    localparam logic [31:0] ID_BOUND_MAX = 32'h003f_ffff;
    localparam logic [31:0] VERSION_PAD_MASK = 32'hff00_00ff;
    localparam logic [7:0] VERSION_MAJOR = 8'd1;
    localparam logic [7:0] VERSION_MINOR_MAX = 8'd6;

    localparam logic [15:0] OP_NAME = 16'd5;
    localparam logic [15:0] OP_ENTRY_POINT = 16'd15;
    localparam logic [15:0] OP_CAPABILITY = 16'd17;
    localparam logic [15:0] OP_TYPE_INT = 16'd21;
    localparam logic [15:0] OP_TYPE_FLOAT = 16'd22;
    localparam logic [15:0] OP_TYPE_VECTOR = 16'd23;
    localparam logic [15:0] OP_TYPE_POINTER = 16'd32;
    localparam logic [15:0] OP_CONSTANT = 16'd43;
    localparam logic [15:0] OP_CONSTANT_COMPOSITE = 16'd44;
    localparam logic [15:0] OP_FUNCTION = 16'd54;
    localparam logic [15:0] OP_VARIABLE = 16'd59;
    localparam logic [15:0] OP_LOAD = 16'd61;
    localparam logic [15:0] OP_STORE = 16'd62;
    localparam logic [15:0] OP_DECORATE = 16'd71;
    localparam logic [15:0] OP_SELECT = 16'd169;
    localparam logic [15:0] OP_TYPE_RANGE_LO = 16'd19;
    localparam logic [15:0] OP_TYPE_RANGE_HI = 16'd39;

    localparam logic [31:0] DEC_LOCATION = 32'd30;
    localparam logic [31:0] DEC_BUILTIN = 32'd11;
    localparam logic [1:0] DEC_KIND_POS = 2'd2;
    localparam logic [1:0] POS_MAX = 2'd3;
    localparam logic [MIN_W-1:0] DEC_IO_MIN = 3'd4;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_SHORT      = 4'd1,
        ERR_LONG       = 4'd2,
        ERR_MAGIC      = 4'd3,
        ERR_VERSION    = 4'd4,
        ERR_BOUND      = 4'd5,
        ERR_SCHEMA     = 4'd6,
        ERR_ZERO_COUNT = 4'd7,
        ERR_TRUNCATED  = 4'd8,
        ERR_FEW_OPS    = 4'd9,
        ERR_MISSING    = 4'd10
    } t_err;

    // One classified word as it passes from the front end to the walker.
    typedef struct packed {
        logic             last;
        logic             hdr;
        t_err             hdr_err;
        logic             short_mod;
        logic             too_long;
        logic [LEN_W-1:0] cnt;
        logic [MIN_W-1:0] op_min;
        logic             op_dec;
        logic             op_ep;
        logic             op_fn;
        logic             dec_io;
    } t_word_rec;

    function automatic logic [MIN_W-1:0] op_minimum(input logic [15:0] op);
        logic [MIN_W-1:0] m;
        case (op)
            OP_NAME:               m = 3'd3;
            OP_ENTRY_POINT:        m = 3'd4;
            OP_CAPABILITY:         m = 3'd2;
            OP_DECORATE:           m = 3'd3;
            OP_VARIABLE:           m = 3'd4;
            OP_TYPE_POINTER:       m = 3'd4;
            OP_TYPE_VECTOR:        m = 3'd4;
            OP_TYPE_FLOAT:         m = 3'd3;
            OP_TYPE_INT:           m = 3'd4;
            OP_CONSTANT:           m = 3'd4;
            OP_CONSTANT_COMPOSITE: m = 3'd4;
            OP_STORE:              m = 3'd3;
            OP_LOAD:               m = 3'd4;
            OP_FUNCTION:           m = 3'd5;
            OP_SELECT:             m = 3'd6;
            default:               m = (op inside {[OP_TYPE_RANGE_LO:OP_TYPE_RANGE_HI]})
                                       ? 3'd2 : 3'd1;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/smec_front.sv =====
// ----------------------------------------------------------------------------
// smec_front
// Accepts module words, keeps the word index and size limit, checks the
// header words and decodes the instruction fields of each word.
// ----------------------------------------------------------------------------
module smec_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_size_limit_words_we,
    input  logic [smec_pkg::IDX_W-1:0]    i_size_limit_words,
    input  logic                          i_accept,
    input  logic [31:0]                   i_word,
    input  logic                          i_last,
    output smec_pkg::t_word_rec           o_rec
);

    logic [smec_pkg::IDX_W-1:0] r_size_limit;
    logic [smec_pkg::IDX_W-1:0] r_word_index;
    logic [smec_pkg::IDX_W-1:0] n_word_index;
    logic                       r_too_long;
    logic                       n_too_long;
    logic [smec_pkg::IDX_W-1:0] limit_eff;
    logic                       too_long_now;

    assign limit_eff = (r_size_limit > smec_pkg::MAX_WORDS_LIMIT)
                       ? smec_pkg::MAX_WORDS_LIMIT : r_size_limit;
    // The word count including this word exceeds the limit exactly when
    // the index has reached it.
    assign too_long_now = r_too_long || (r_word_index >= limit_eff);

    always_comb begin
        o_rec = '0;
        o_rec.last      = i_last;
        o_rec.hdr       = (r_word_index < smec_pkg::HEADER_WORDS);
        o_rec.short_mod = (r_word_index < (smec_pkg::HEADER_WORDS - 21'd1));
        o_rec.too_long  = too_long_now;
        o_rec.hdr_err   = smec_pkg::ERR_NONE;
        if (r_word_index == smec_pkg::HDR_MAGIC_IDX) begin
            if (i_word != smec_pkg::MAGIC_WORD) begin
                o_rec.hdr_err = smec_pkg::ERR_MAGIC;
            end
        end else if (r_word_index == smec_pkg::HDR_VERSION_IDX) begin
            if (((i_word & smec_pkg::VERSION_PAD_MASK) != 32'd0) ||
                (i_word[23:16] != smec_pkg::VERSION_MAJOR) ||
                (i_word[15:8] > smec_pkg::VERSION_MINOR_MAX)) begin
                o_rec.hdr_err = smec_pkg::ERR_VERSION;
            end
        end else if (r_word_index == smec_pkg::HDR_BOUND_IDX) begin
            if ((i_word == 32'd0) || (i_word > smec_pkg::ID_BOUND_MAX)) begin
                o_rec.hdr_err = smec_pkg::ERR_BOUND;
            end
        end else if (r_word_index == smec_pkg::HDR_SCHEMA_IDX) begin
            if (i_word != 32'd0) begin
                o_rec.hdr_err = smec_pkg::ERR_SCHEMA;
            end
        end
        o_rec.cnt    = i_word[31:16];
        o_rec.op_min = smec_pkg::op_minimum(i_word[15:0]);
        o_rec.op_dec = (i_word[15:0] == smec_pkg::OP_DECORATE);
        o_rec.op_ep  = (i_word[15:0] == smec_pkg::OP_ENTRY_POINT);
        o_rec.op_fn  = (i_word[15:0] == smec_pkg::OP_FUNCTION);
        o_rec.dec_io = (i_word == smec_pkg::DEC_LOCATION) ||
                       (i_word == smec_pkg::DEC_BUILTIN);
    end

    always_comb begin
        n_word_index = r_word_index;
        n_too_long   = r_too_long;
        if (i_accept) begin
            if (i_last) begin
                n_word_index = '0;
                n_too_long   = 1'b0;
            end else begin
                n_too_long = too_long_now;
                if (r_word_index != smec_pkg::INDEX_MAX) begin
                    n_word_index = r_word_index + 21'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_limit <= smec_pkg::SIZE_LIMIT_RESET;
            r_word_index <= '0;
            r_too_long   <= 1'b0;
        end else begin
            if (i_size_limit_words_we) begin
                r_size_limit <= i_size_limit_words;
            end
            r_word_index <= n_word_index;
            r_too_long   <= n_too_long;
        end
    end

endmodule

// ===== hw/rtl/smec_queue.sv =====
// ----------------------------------------------------------------------------
// smec_queue
// Two-entry register queue of classified words between front and back.
// ----------------------------------------------------------------------------
`include "spirv_module_envelope_checker_assert.svh"

module smec_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  smec_pkg::t_word_rec   i_rec,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output smec_pkg::t_word_rec   o_rec
);

    smec_pkg::t_word_rec              r_mem [smec_pkg::Q_DEPTH];
    logic [smec_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [smec_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [smec_pkg::Q_CNT_W-1:0]     r_count;

    assign o_full  = (r_count == smec_pkg::Q_CNT_W'(smec_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // The depth is a power of two, so the pointers wrap by truncation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + smec_pkg::Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + smec_pkg::Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + smec_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - smec_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `SMEC_ASSERT(a_no_pop_empty, i_clk, i_rst_n, !i_pop || o_valid, "queue popped while empty")
    `SMEC_ASSERT(a_no_push_full, i_clk, i_rst_n, !i_push || !o_full, "queue pushed while full")
    `SMEC_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, i_pop && !i_push,
        r_count == $past(r_count) - smec_pkg::Q_CNT_W'(1), "queue count not reduced by pop")

endmodule

// ===== hw/rtl/smec_back.sv =====
// ----------------------------------------------------------------------------
// smec_back
// Walks the instruction stream word by word, latches the first error and
// delivers the verdict for each module through an output register.
// ----------------------------------------------------------------------------
`include "spirv_module_envelope_checker_assert.svh"

module smec_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  smec_pkg::t_word_rec   i_rec,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_envelope_ok,
    output logic                  o_inspector_ok,
    output logic [3:0]            o_error_code
);

    logic [smec_pkg::LEN_W-1:0] r_words_left;
    logic [smec_pkg::LEN_W-1:0] n_words_left;
    logic [1:0]                 r_pos;
    logic [1:0]                 n_pos;
    logic [smec_pkg::LEN_W-1:0] r_inst_len;
    logic [smec_pkg::LEN_W-1:0] n_inst_len;
    logic                       r_cur_dec;
    logic                       n_cur_dec;
    logic [smec_pkg::MIN_W-1:0] r_min_words;
    logic [smec_pkg::MIN_W-1:0] n_min_words;
    smec_pkg::t_err             r_first_error;
    smec_pkg::t_err             n_first_error;
    logic                       r_seen_ep;
    logic                       n_seen_ep;
    logic                       r_seen_fn;
    logic                       n_seen_fn;

    logic                       r_out_valid;
    logic                       r_env_ok;
    logic                       r_insp_ok;
    smec_pkg::t_err             r_err_code;

    smec_pkg::t_err             res_err;
    smec_pkg::t_err             res_code;
    logic                       res_env;
    logic                       res_insp;

    // A non-final word never waits; the final word needs the result slot.
    assign o_pop = i_q_valid && (!i_rec.last || !r_out_valid || !i_out_stall);

    always_comb begin
        n_words_left  = r_words_left;
        n_pos         = r_pos;
        n_inst_len    = r_inst_len;
        n_cur_dec     = r_cur_dec;
        n_min_words   = r_min_words;
        n_first_error = r_first_error;
        n_seen_ep     = r_seen_ep;
        n_seen_fn     = r_seen_fn;
        if (i_rec.hdr) begin
            if (r_first_error == smec_pkg::ERR_NONE) begin
                n_first_error = i_rec.hdr_err;
            end
        end else if (r_first_error == smec_pkg::ERR_NONE) begin
            if (r_words_left == '0) begin
                if (i_rec.cnt == '0) begin
                    n_first_error = smec_pkg::ERR_ZERO_COUNT;
                end else begin
                    n_inst_len   = i_rec.cnt;
                    n_words_left = i_rec.cnt;
                    n_pos        = '0;
                    n_cur_dec    = i_rec.op_dec;
                    n_min_words  = i_rec.op_min;
                    n_seen_ep    = r_seen_ep || i_rec.op_ep;
                    n_seen_fn    = r_seen_fn || i_rec.op_fn;
                end
            end
            if (n_first_error == smec_pkg::ERR_NONE) begin
                if ((n_pos == smec_pkg::DEC_KIND_POS) && n_cur_dec && i_rec.dec_io) begin
                    n_min_words = smec_pkg::DEC_IO_MIN;
                end
                if (n_pos != smec_pkg::POS_MAX) begin
                    n_pos = n_pos + 2'd1;
                end
                n_words_left = n_words_left - 16'd1;
                if (n_words_left == '0) begin
                    if (n_inst_len < {{(smec_pkg::LEN_W-smec_pkg::MIN_W){1'b0}},
                                      n_min_words}) begin
                        n_first_error = smec_pkg::ERR_FEW_OPS;
                    end
                end else if (i_rec.last) begin
                    n_first_error = smec_pkg::ERR_TRUNCATED;
                end
            end
        end

        if (i_rec.short_mod) begin
            res_err = smec_pkg::ERR_SHORT;
        end else if (i_rec.too_long) begin
            res_err = smec_pkg::ERR_LONG;
        end else begin
            res_err = n_first_error;
        end
        res_env  = (res_err == smec_pkg::ERR_NONE);
        res_insp = res_env && n_seen_ep && n_seen_fn;
        res_code = (res_env && !res_insp) ? smec_pkg::ERR_MISSING : res_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_left  <= '0;
            r_pos         <= '0;
            r_inst_len    <= '0;
            r_cur_dec     <= 1'b0;
            r_min_words   <= '0;
            r_first_error <= smec_pkg::ERR_NONE;
            r_seen_ep     <= 1'b0;
            r_seen_fn     <= 1'b0;
        end else if (o_pop) begin
            if (i_rec.last) begin
                r_words_left  <= '0;
                r_pos         <= '0;
                r_inst_len    <= '0;
                r_cur_dec     <= 1'b0;
                r_min_words   <= '0;
                r_first_error <= smec_pkg::ERR_NONE;
                r_seen_ep     <= 1'b0;
                r_seen_fn     <= 1'b0;
            end else begin
                r_words_left  <= n_words_left;
                r_pos         <= n_pos;
                r_inst_len    <= n_inst_len;
                r_cur_dec     <= n_cur_dec;
                r_min_words   <= n_min_words;
                r_first_error <= n_first_error;
                r_seen_ep     <= n_seen_ep;
                r_seen_fn     <= n_seen_fn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_rec.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_rec.last) begin
            r_env_ok   <= res_env;
            r_insp_ok  <= res_insp;
            r_err_code <= res_code;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_envelope_ok  = r_env_ok;
    assign o_inspector_ok = r_insp_ok;
    assign o_error_code   = r_err_code;

    `SMEC_ASSERT(a_insp_needs_env, i_clk, i_rst_n, !r_out_valid || !r_insp_ok || r_env_ok,
        "inspector verdict without a valid envelope")
    `SMEC_ASSERT(a_code_matches, i_clk, i_rst_n,
        !r_out_valid || (r_env_ok == ((r_err_code == smec_pkg::ERR_NONE) ||
                                      (r_err_code == smec_pkg::ERR_MISSING))),
        "error code disagrees with envelope verdict")
    `SMEC_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, o_pop && i_rec.last,
        (r_first_error == smec_pkg::ERR_NONE) && (r_words_left == '0) && !r_seen_ep,
        "walker state not cleared after final word")

endmodule

// ===== hw/rtl/spirv_module_envelope_checker.sv =====
// ----------------------------------------------------------------------------
// spirv_module_envelope_checker
// Checks the header and instruction framing of a SPIR-V module streamed in
// one word per cycle and reports one verdict per module.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_word, i_last
//   output    out        o_out_valid / i_out_stall  o_envelope_ok, o_inspector_ok,
//                                                   o_error_code
//   config    in         i_size_limit_words_we      i_size_limit_words
//
// One word is taken every cycle while the queue has room; the front end
// decodes each word combinationally as it is taken, and the instruction
// walker handles it at the queue head. The verdict is loaded into the
// output register as the walker pops the final word from the queue.
// Synchronous reset clears all stream state and sets the size limit to 262144.
// A stalled verdict holds in its output register; non-final words keep
// flowing, and input stalls only when the two-entry queue fills.
// ----------------------------------------------------------------------------
module spirv_module_envelope_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_size_limit_words_we,
    input  logic [smec_pkg::IDX_W-1:0]    i_size_limit_words,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [31:0]                   i_word,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_envelope_ok,
    output logic                          o_inspector_ok,
    output logic [3:0]                    o_error_code
);

    smec_pkg::t_word_rec front_rec;
    smec_pkg::t_word_rec back_rec;
    logic                accept;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    smec_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_size_limit_words_we (i_size_limit_words_we),
        .i_size_limit_words    (i_size_limit_words),
        .i_accept              (accept),
        .i_word                (i_word),
        .i_last                (i_last),
        .o_rec                 (front_rec)
    );

    smec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (back_rec)
    );

    smec_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_rec          (back_rec),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_envelope_ok  (o_envelope_ok),
        .o_inspector_ok (o_inspector_ok),
        .o_error_code   (o_error_code)
    );

endmodule

// ===== dv/tb_spirv_module_envelope_checker.sv =====
// ----------------------------------------------------------------------------
// tb_spirv_module_envelope_checker
// Streams SPIR-V modules into the envelope checker, one word per handshake,
// and compares every verdict with an expected one: a short table of
// hand-built modules with written-in verdicts comes first, then random
// modules under several size limits, checked against an in-bench prediction
// of header checks, instruction framing and the entry point / function need.
// ----------------------------------------------------------------------------
module tb_spirv_module_envelope_checker;

    typedef struct packed {
        logic           env_ok;
        logic           insp_ok;
        smec_pkg::t_err err;
    } t_verdict;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        typed;
        t_verdict    v;
    } t_row;

    localparam t_verdict NO_VERDICT = '{1'b0, 1'b0, smec_pkg::ERR_NONE};
    localparam int unsigned N_ROWS = 26;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_size_limit_words_we = 1'b0;
    logic [smec_pkg::IDX_W-1:0] i_size_limit_words = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [31:0]                i_word = '0;
    logic                       i_last = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_envelope_ok;
    logic                       o_inspector_ok;
    logic [3:0]                 o_error_code;

    spirv_module_envelope_checker u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_size_limit_words_we (i_size_limit_words_we),
        .i_size_limit_words    (i_size_limit_words),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_word                (i_word),
        .i_last                (i_last),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_envelope_ok         (o_envelope_ok),
        .o_inspector_ok        (o_inspector_ok),
        .o_error_code          (o_error_code)
    );

    // Predicted stream state, kept in step with every accepted word.
    logic [smec_pkg::IDX_W-1:0] p_limit;
    logic [smec_pkg::IDX_W-1:0] p_index;
    logic [smec_pkg::LEN_W-1:0] p_left;
    logic [1:0]                 p_pos;
    logic [smec_pkg::LEN_W-1:0] p_len;
    logic [smec_pkg::MIN_W-1:0] p_min;
    logic                       p_is_dec;
    logic                       p_ep;
    logic                       p_fn;
    logic                       p_too_long;
    smec_pkg::t_err             p_err;

    t_verdict    pending_verdicts [$];
    logic [31:0] spv_words [$];
    int unsigned mismatch_count = 0;
    int unsigned burst_left = 0;
    int unsigned rx_cycle = 0;
    int unsigned rx_run = 0;
    logic        rx_hold = 1'b0;

    // Hand-built modules: a one-word module, a bare valid header, a zero word
    // count, an instruction cut off by the end, and a Decorate naming Location
    // that is one word too short.
    t_row directed_rows [N_ROWS] = '{
        '{32'h0000_0000, 1'b1, 1'b1, '{1'b0, 1'b0, smec_pkg::ERR_SHORT}},
        '{smec_pkg::MAGIC_WORD,   1'b0, 1'b0, NO_VERDICT},
        '{32'h0001_0600, 1'b0, 1'b0, NO_VERDICT},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_VERDICT},
        '{smec_pkg::ID_BOUND_MAX, 1'b0, 1'b0, NO_VERDICT},
        '{32'h0000_0000, 1'b1, 1'b1, '{1'b1, 1'b0, smec_pkg::ERR_MISSING}},
        '{smec_pkg::MAGIC_WORD,   1'b0, 1'b0, NO_VERDICT},
        '{32'h0001_0000, 1'b0, 1'b0, NO_VERDICT},
        '{32'h0000_0000, 1'b0, 1'b0, NO_VERDICT},
        '{32'h0000_0001, 1'b0, 1'b0, NO_VERDICT},
        '{32'h0000_0000, 1'b0, 1'b0, NO_VERDICT},
        '{{16'd0, smec_pkg::OP_DECORATE}, 1'b1, 1'b1,
          '{1'b0, 1'b0, smec_pkg::ERR_ZERO_COUNT}},
        '{smec_pkg::MAGIC_WORD,   1'b0, 1'b0, NO_VERDICT},
        '{32'h0001_0300, 1'b0, 1'b0, NO_VERDICT},
        '{32'h1234_5678, 1'b0, 1'b0, NO_VERDICT},
        '{32'h0000_0100, 1'b0, 1'b0, NO_VERDICT},
        '{32'h0000_0000, 1'b0, 1'b0, NO_VERDICT},
        '{{16'd2, smec_pkg::OP_CAPABILITY}, 1'b1, 1'b1,
          '{1'b0, 1'b0, smec_pkg::ERR_TRUNCATED}},
        '{smec_pkg::MAGIC_WORD,   1'b0, 1'b0, NO_VERDICT},
        '{32'h0001_0500, 1'b0, 1'b0, NO_VERDICT},
        '{32'h0000_0000, 1'b0, 1'b0, NO_VERDICT},
        '{smec_pkg::ID_BOUND_MAX, 1'b0, 1'b0, NO_VERDICT},
        '{32'h0000_0000, 1'b0, 1'b0, NO_VERDICT},
        '{{16'd3, smec_pkg::OP_DECORATE}, 1'b0, 1'b0, NO_VERDICT},
        '{32'h0000_0007, 1'b0, 1'b0, NO_VERDICT},
        '{smec_pkg::DEC_LOCATION, 1'b1, 1'b1, '{1'b0, 1'b0, smec_pkg::ERR_FEW_OPS}}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic bit coin(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [smec_pkg::MIN_W-1:0] min_words_for(input logic [15:0] op);
        case (op)
            smec_pkg::OP_CAPABILITY: return 3'd2;
            smec_pkg::OP_NAME, smec_pkg::OP_TYPE_FLOAT, smec_pkg::OP_DECORATE,
            smec_pkg::OP_STORE: return 3'd3;
            smec_pkg::OP_ENTRY_POINT, smec_pkg::OP_VARIABLE, smec_pkg::OP_TYPE_POINTER,
            smec_pkg::OP_TYPE_VECTOR, smec_pkg::OP_TYPE_INT, smec_pkg::OP_CONSTANT,
            smec_pkg::OP_CONSTANT_COMPOSITE, smec_pkg::OP_LOAD: return 3'd4;
            smec_pkg::OP_FUNCTION: return 3'd5;
            smec_pkg::OP_SELECT: return 3'd6;
            default: return (op >= smec_pkg::OP_TYPE_RANGE_LO &&
                             op <= smec_pkg::OP_TYPE_RANGE_HI) ? 3'd2 : 3'd1;
        endcase
    endfunction

    function automatic void clear_stream_state();
        p_index = '0;
        p_left = '0;
        p_pos = '0;
        p_len = '0;
        p_min = '0;
        p_is_dec = 1'b0;
        p_ep = 1'b0;
        p_fn = 1'b0;
        p_too_long = 1'b0;
        p_err = smec_pkg::ERR_NONE;
    endfunction

    function automatic void flag_error(input smec_pkg::t_err code);
        if (p_err == smec_pkg::ERR_NONE) begin
            p_err = code;
        end
    endfunction

    // Advances the predicted state by one word; on the final word it gives
    // the verdict and starts a fresh module.
    task automatic step_envelope(input logic [31:0] w, input logic l,
                                 output bit done, output t_verdict v);
        logic [smec_pkg::IDX_W-1:0] idx;
        int unsigned                n_words;
        int unsigned                lim;
        smec_pkg::t_err             code;
        done = 1'b0;
        v = NO_VERDICT;
        idx = p_index;
        n_words = idx + 1;
        lim = (p_limit > smec_pkg::MAX_WORDS_LIMIT) ? smec_pkg::MAX_WORDS_LIMIT : p_limit;
        if (n_words > lim) begin
            p_too_long = 1'b1;
        end
        if (idx < smec_pkg::HEADER_WORDS) begin
            if (idx == smec_pkg::HDR_MAGIC_IDX && w != smec_pkg::MAGIC_WORD) begin
                flag_error(smec_pkg::ERR_MAGIC);
            end
            if (idx == smec_pkg::HDR_VERSION_IDX &&
                ((w & smec_pkg::VERSION_PAD_MASK) != 0 ||
                 w[23:16] != smec_pkg::VERSION_MAJOR ||
                 w[15:8] > smec_pkg::VERSION_MINOR_MAX)) begin
                flag_error(smec_pkg::ERR_VERSION);
            end
            if (idx == smec_pkg::HDR_BOUND_IDX &&
                (w == 0 || w > smec_pkg::ID_BOUND_MAX)) begin
                flag_error(smec_pkg::ERR_BOUND);
            end
            if (idx == smec_pkg::HDR_SCHEMA_IDX && w != 0) begin
                flag_error(smec_pkg::ERR_SCHEMA);
            end
        end else if (p_err == smec_pkg::ERR_NONE) begin
            if (p_left == 0) begin
                if (w[31:16] == 0) begin
                    flag_error(smec_pkg::ERR_ZERO_COUNT);
                end else begin
                    p_len = w[31:16];
                    p_left = w[31:16];
                    p_pos = '0;
                    p_is_dec = (w[15:0] == smec_pkg::OP_DECORATE);
                    p_min = min_words_for(w[15:0]);
                    if (w[15:0] == smec_pkg::OP_ENTRY_POINT) begin
                        p_ep = 1'b1;
                    end
                    if (w[15:0] == smec_pkg::OP_FUNCTION) begin
                        p_fn = 1'b1;
                    end
                end
            end
            if (p_err == smec_pkg::ERR_NONE) begin
                if (p_pos == smec_pkg::DEC_KIND_POS && p_is_dec &&
                    (w == smec_pkg::DEC_LOCATION || w == smec_pkg::DEC_BUILTIN)) begin
                    p_min = smec_pkg::DEC_IO_MIN;
                end
                if (p_pos < smec_pkg::POS_MAX) begin
                    p_pos++;
                end
                p_left--;
                if (p_left == 0) begin
                    if (p_len < p_min) begin
                        flag_error(smec_pkg::ERR_FEW_OPS);
                    end
                end else if (l) begin
                    flag_error(smec_pkg::ERR_TRUNCATED);
                end
            end
        end
        if (p_index != smec_pkg::INDEX_MAX) begin
            p_index++;
        end
        if (l) begin
            if (n_words < smec_pkg::HEADER_WORDS) begin
                code = smec_pkg::ERR_SHORT;
            end else if (p_too_long) begin
                code = smec_pkg::ERR_LONG;
            end else begin
                code = p_err;
            end
            v.env_ok = (code == smec_pkg::ERR_NONE);
            v.insp_ok = v.env_ok && p_ep && p_fn;
            if (v.env_ok && !v.insp_ok) begin
                code = smec_pkg::ERR_MISSING;
            end
            v.err = code;
            done = 1'b1;
            clear_stream_state();
        end
    endtask

    // The sender runs in bursts, and valid drops between them.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = coin(20) ? $urandom_range(60, 120) : $urandom_range(0, 15);
        end
    endtask

    task automatic send_word(input logic [31:0] w, input logic l,
                             input logic typed, input t_verdict tv);
        bit       done;
        t_verdict pv;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_word <= w;
        i_last <= l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        step_envelope(w, l, done, pv);
        if (done) begin
            pending_verdicts.push_back(typed ? tv : pv);
        end
        pace_sender();
    endtask

    task automatic wait_for_verdicts();
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_verdicts.size() != 0) begin
            $display("%0t: expected %0d more verdicts, got none", $time,
                     pending_verdicts.size());
            mismatch_count++;
            pending_verdicts.delete();
        end
    endtask

    task automatic set_size_limit(input logic [smec_pkg::IDX_W-1:0] v);
        wait_for_verdicts();
        // Let the last verdict clear the output stage before the write.
        repeat (4) @(negedge i_clk);
        i_size_limit_words_we <= 1'b1;
        i_size_limit_words <= v;
        @(negedge i_clk);
        i_size_limit_words_we <= 1'b0;
        p_limit = v;
    endtask

    function automatic logic [15:0] pick_op();
        case ($urandom_range(0, 19))
            0: return smec_pkg::OP_NAME;
            1: return smec_pkg::OP_ENTRY_POINT;
            2: return smec_pkg::OP_CAPABILITY;
            3: return smec_pkg::OP_DECORATE;
            4: return smec_pkg::OP_VARIABLE;
            5: return smec_pkg::OP_TYPE_POINTER;
            6: return smec_pkg::OP_TYPE_VECTOR;
            7: return smec_pkg::OP_TYPE_FLOAT;
            8: return smec_pkg::OP_TYPE_INT;
            9: return smec_pkg::OP_CONSTANT;
            10: return smec_pkg::OP_CONSTANT_COMPOSITE;
            11: return smec_pkg::OP_STORE;
            12: return smec_pkg::OP_LOAD;
            13: return smec_pkg::OP_FUNCTION;
            14: return smec_pkg::OP_SELECT;
            15, 16: return 16'($urandom_range(smec_pkg::OP_TYPE_RANGE_LO,
                                               smec_pkg::OP_TYPE_RANGE_HI));
            default: return 16'($urandom);
        endcase
    endfunction

    // Appends one instruction whose word count is its minimum plus delta, but at least one.
    task automatic add_instr(input logic [15:0] op, input int delta);
        logic [31:0] deco;
        int          need;
        int          cnt;
        int          k;
        case ($urandom_range(0, 2))
            0: deco = smec_pkg::DEC_LOCATION;
            1: deco = smec_pkg::DEC_BUILTIN;
            default: deco = $urandom;
        endcase
        need = min_words_for(op);
        if (op == smec_pkg::OP_DECORATE &&
            (deco == smec_pkg::DEC_LOCATION || deco == smec_pkg::DEC_BUILTIN)) begin
            need = smec_pkg::DEC_IO_MIN;
        end
        cnt = need + delta;
        if (cnt < 1) begin
            cnt = 1;
        end
        spv_words.push_back({16'(cnt), op});
        for (k = 1; k < cnt; k++) begin
            // Other opcodes sometimes carry a decoration value too, which
            // must not raise their minimum.
            spv_words.push_back((k == 2 && (op == smec_pkg::OP_DECORATE || coin(20)))
                                ? deco : $urandom);
        end
    endtask

    task automatic add_trailing_words();
        if (coin(40)) begin
            repeat ($urandom_range(1, 3)) spv_words.push_back($urandom);
        end
    endtask

    task automatic build_module();
        int unsigned kind;
        int unsigned k;
        int unsigned cnt;
        logic [31:0] w;
        spv_words.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            k = $urandom_range(1, 4);
            repeat (k) spv_words.push_back((spv_words.size() == 0 && coin(50))
                                           ? smec_pkg::MAGIC_WORD : $urandom);
        end else if (kind >= 94) begin
            repeat ($urandom_range(1, 12)) spv_words.push_back($urandom);
        end else begin
            spv_words.push_back(smec_pkg::MAGIC_WORD);
            spv_words.push_back({8'h00, smec_pkg::VERSION_MAJOR,
                                 8'($urandom_range(0, smec_pkg::VERSION_MINOR_MAX)),
                                 8'h00});
            spv_words.push_back($urandom);
            case ($urandom_range(0, 2))
                0: spv_words.push_back(32'd1);
                1: spv_words.push_back(smec_pkg::ID_BOUND_MAX);
                default: spv_words.push_back($urandom_range(1, smec_pkg::ID_BOUND_MAX));
            endcase
            spv_words.push_back(32'd0);
            if (kind < 20) begin
                repeat ($urandom_range(1, 2)) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            w = $urandom;
                            spv_words[0] = (w == smec_pkg::MAGIC_WORD) ? ~w : w;
                        end
                        1: begin
                            case ($urandom_range(0, 3))
                                0: spv_words[1] = {8'h00, smec_pkg::VERSION_MAJOR, 8'h00,
                                                   8'($urandom_range(1, 255))};
                                1: spv_words[1] = {8'($urandom_range(1, 255)),
                                                   smec_pkg::VERSION_MAJOR, 8'h00, 8'h00};
                                2: spv_words[1] = {8'h00,
                                                   coin(50) ? 8'h00
                                                            : 8'($urandom_range(2, 255)),
                                                   8'h00, 8'h00};
                                default: spv_words[1] = {8'h00, smec_pkg::VERSION_MAJOR,
                                                         8'($urandom_range(7, 255)), 8'h00};
                            endcase
                        end
                        2: spv_words[3] = coin(50) ? 32'd0
                                                   : $urandom_range(32'h0040_0000,
                                                                    32'hFFFF_FFFF);
                        default: spv_words[4] = $urandom_range(1, 32'hFFFF_FFFF);
                    endcase
                end
            end
            if (coin(60)) begin
                add_instr(smec_pkg::OP_ENTRY_POINT, $urandom_range(0, 2));
            end
            repeat ($urandom_range(0, 3)) add_instr(pick_op(), $urandom_range(0, 2));
            if (coin(60)) begin
                add_instr(smec_pkg::OP_FUNCTION, $urandom_range(0, 2));
            end
            if (kind >= 20 && kind < 34) begin
                case ($urandom_range(0, 2))
                    0: begin
                        spv_words.push_back({16'd0, 16'($urandom)});
                        add_trailing_words();
                    end
                    1: begin
                        // The module ends while the instruction still has words due.
                        k = $urandom_range(0, 2);
                        cnt = $urandom_range(k + 2, 16'hFFFF);
                        spv_words.push_back({16'(cnt), pick_op()});
                        repeat (k) spv_words.push_back($urandom);
                    end
                    default: begin
                        case ($urandom_range(0, 4))
                            0: w[15:0] = smec_pkg::OP_SELECT;
                            1: w[15:0] = smec_pkg::OP_FUNCTION;
                            2: w[15:0] = smec_pkg::OP_ENTRY_POINT;
                            3: w[15:0] = smec_pkg::OP_DECORATE;
                            default: w[15:0] = smec_pkg::OP_CAPABILITY;
                        endcase
                        add_instr(w[15:0], -int'($urandom_range(1, 3)));
                        add_trailing_words();
                    end
                endcase
            end
        end
    endtask

    // Receiver back-pressure: free-running, random, then long on/off runs.
    always @(negedge i_clk) begin
        rx_cycle++;
        case ((rx_cycle / 160) % 3)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                if (rx_run == 0) begin
                    rx_hold = !rx_hold;
                    rx_run = rx_hold ? $urandom_range(1, 12) : $urandom_range(1, 5);
                end
                rx_run--;
                i_out_stall <= rx_hold;
            end
        endcase
    end

    always @(posedge i_clk) begin : verdict_check
        t_verdict ev;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: verdict expected none, got env %0b insp %0b code %0d",
                         $time, o_envelope_ok, o_inspector_ok, o_error_code);
                mismatch_count++;
            end else begin
                ev = pending_verdicts.pop_front();
                if (o_envelope_ok !== ev.env_ok) begin
                    $display("%0t: envelope_ok expected %0b got %0b", $time,
                             ev.env_ok, o_envelope_ok);
                    mismatch_count++;
                end
                if (o_inspector_ok !== ev.insp_ok) begin
                    $display("%0t: inspector_ok expected %0b got %0b", $time,
                             ev.insp_ok, o_inspector_ok);
                    mismatch_count++;
                end
                if (o_error_code !== ev.err) begin
                    $display("%0t: error_code expected %0d got %0d", $time,
                             ev.err, o_error_code);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int unsigned                ph;
        int unsigned                k;
        int unsigned                sent;
        int unsigned                mods;
        logic [smec_pkg::IDX_W-1:0] lim;
        p_limit = smec_pkg::SIZE_LIMIT_RESET;
        clear_stream_state();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_ROWS; k++) begin
            send_word(directed_rows[k].word, directed_rows[k].last,
                      directed_rows[k].typed, directed_rows[k].v);
        end

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: lim = 21'd1048575;
                1: lim = smec_pkg::HEADER_WORDS;
                2: lim = smec_pkg::MAX_WORDS_LIMIT;
                3: lim = 21'($urandom_range(6, 30));
                default: lim = 21'($urandom_range(5, 12));
            endcase
            set_size_limit(lim);
            sent = 0;
            mods = 0;
            while (sent < 80 || mods < 4) begin
                if ($urandom_range(0, 19) == 0) begin
                    wait_for_verdicts();
                end
                build_module();
                for (k = 0; k < spv_words.size(); k++) begin
                    send_word(spv_words[k], k == spv_words.size() - 1, 1'b0, NO_VERDICT);
                end
                sent += spv_words.size();
                mods++;
            end
        end

        wait_for_verdicts();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
